// File: rtl/contrastive_loss_forward_top_defines.svh
// assertion macros for the contrastive loss forward block
// used by the top level only; no other dependencies
`ifndef CONTRASTIVE_LOSS_FORWARD_TOP_DEFINES_SVH
`define CONTRASTIVE_LOSS_FORWARD_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CLF_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CLF_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CLF_ASSERT_IMP(name, ante, cons)
`define CLF_ASSERT_NXT(name, ante, cons)
`endif
`endif

// File: rtl/clf_pkg.sv
// shared types and constants for the contrastive loss forward block
// no dependencies
package clf_pkg;

  localparam int unsigned D2W     = 43;
  localparam int unsigned SQW     = 34;
  localparam int unsigned MARGINW = 32;
  localparam int unsigned LOSSW   = 64;
  localparam int unsigned OUTW    = 48;
  localparam int unsigned PCW     = 17;
  localparam int unsigned TERMW   = 48;
  localparam int unsigned ROOTW   = 30;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QCNTW   = $clog2(QDEPTH + 1);
  localparam int unsigned PAIRS_MAX_DEF = 65536;

  localparam logic [D2W-1:0] D2_MAX = {D2W{1'b1}};

  typedef enum logic {
    REG_MARGIN = 1'b0,
    REG_LEGACY = 1'b1
  } reg_idx_e;

  // one finished vector pair, handed from front to back
  typedef struct packed {
    logic [D2W-1:0] d2;
    logic           similar;
    logic           last_pair;
    logic           ovf;
  } pair_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQRT,
    B_MUL,
    B_RND,
    B_ACC,
    B_DIV,
    B_OUT
  } back_state_e;

endpackage

// File: rtl/clf_front.sv
// front end: takes element pairs, squares differences, sums per vector pair
// depends on clf_pkg
module clf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic signed [15:0]            elem_a_i,
  input  logic signed [15:0]            elem_b_i,
  input  logic                          similar_pair_i,
  input  logic                          last_channel_i,
  input  logic                          last_pair_i,
  input  logic [clf_pkg::QCNTW-1:0]     q_cnt_i,
  output logic                          q_push_o,
  output clf_pkg::pair_t                q_data_o
);

  logic                      s0_v_q;
  logic [clf_pkg::SQW-1:0]   sq_q;
  logic                      sim_q, lc_q, lp_q;
  logic [clf_pkg::D2W-1:0]   d2_q, d2_d;
  logic                      ovf_q, ovf_d;
  logic                      accept;
  logic signed [16:0]        diff;
  logic [16:0]               mag;
  logic [clf_pkg::D2W:0]     sum;
  logic                      sat;

  // reserve a queue slot for the item already in the square stage
  assign full_o = (32'(q_cnt_i) + 32'(s0_v_q)) >= clf_pkg::QDEPTH;
  assign accept = push_i & ~full_o;

  assign diff = 17'(elem_a_i) - 17'(elem_b_i);
  assign mag  = diff[16] ? 17'(-diff) : 17'(diff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else begin
      s0_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sq_q  <= clf_pkg::SQW'(mag * mag);
      sim_q <= similar_pair_i;
      lc_q  <= last_channel_i;
      lp_q  <= last_pair_i;
    end
  end

  assign sum = {1'b0, d2_q} + (clf_pkg::D2W + 1)'(sq_q);
  assign sat = sum[clf_pkg::D2W];

  always_comb begin
    d2_d  = d2_q;
    ovf_d = ovf_q;
    if (s0_v_q) begin
      if (lc_q) begin
        d2_d  = '0;
        ovf_d = 1'b0;
      end else begin
        d2_d  = sat ? clf_pkg::D2_MAX : sum[clf_pkg::D2W-1:0];
        ovf_d = ovf_q | sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d2_q  <= '0;
      ovf_q <= 1'b0;
    end else begin
      d2_q  <= d2_d;
      ovf_q <= ovf_d;
    end
  end

  assign q_push_o           = s0_v_q & lc_q;
  assign q_data_o.d2        = sat ? clf_pkg::D2_MAX : sum[clf_pkg::D2W-1:0];
  assign q_data_o.similar   = sim_q;
  assign q_data_o.last_pair = lp_q;
  assign q_data_o.ovf       = ovf_q | sat;

endmodule

// File: rtl/clf_queue.sv
// short queue of finished vector pairs between front and back
// depends on clf_pkg
module clf_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  clf_pkg::pair_t            data_i,
  input  logic                      pop_i,
  output clf_pkg::pair_t            data_o,
  output logic                      empty_o,
  output logic [clf_pkg::QCNTW-1:0] cnt_o
);

  localparam int unsigned PW = $clog2(clf_pkg::QDEPTH);

  clf_pkg::pair_t            mem [clf_pkg::QDEPTH];
  logic [PW-1:0]             wp_q, rp_q;
  logic [clf_pkg::QCNTW-1:0] cnt_q;
  logic                      do_pop;

  assign do_pop  = pop_i & (cnt_q != '0);
  assign empty_o = (cnt_q == '0);
  assign cnt_o   = cnt_q;
  assign data_o  = mem[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (32'(wp_q) == clf_pkg::QDEPTH - 1) ? '0 : PW'(wp_q + 1'b1);
      if (do_pop) rp_q <= (32'(rp_q) == clf_pkg::QDEPTH - 1) ? '0 : PW'(rp_q + 1'b1);
      cnt_q <= clf_pkg::QCNTW'(cnt_q + clf_pkg::QCNTW'(push_i) - clf_pkg::QCNTW'(do_pop));
    end
  end

endmodule

// File: rtl/clf_back.sv
// back end: loss term per pair (square root, square), batch sum and divide
// depends on clf_pkg
module clf_back #(
  parameter int unsigned PAIRS_MAX = clf_pkg::PAIRS_MAX_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [clf_pkg::MARGINW-1:0]   margin_i,
  input  logic                          legacy_i,
  input  logic                          q_empty_i,
  input  clf_pkg::pair_t                q_data_i,
  output logic                          q_pop_o,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [clf_pkg::OUTW-1:0]      loss_value_o,
  output logic                          loss_saturated_o,
  output logic [clf_pkg::PCW-1:0]       pair_total_o
);

  localparam logic [clf_pkg::PCW-1:0] PC_MAX = clf_pkg::PCW'(PAIRS_MAX);
  localparam int unsigned XW = 2 * clf_pkg::ROOTW;

  clf_pkg::back_state_e st_q, st_d;
  clf_pkg::pair_t       ent_q;

  logic [XW-1:0]                  x_q;
  logic [clf_pkg::ROOTW-1:0]      root_q;
  logic [clf_pkg::ROOTW+2:0]      rem_q;
  logic [4:0]                     it_q;
  logic [63:0]                    prod_q;
  logic [clf_pkg::TERMW-1:0]      term_q;
  logic [clf_pkg::LOSSW-1:0]      loss_q;
  logic [clf_pkg::PCW-1:0]        pc_q;
  logic                           flag_q;
  logic [63:0]                    dvd_q, quo_q;
  logic [clf_pkg::PCW:0]          dsr_q;
  logic [clf_pkg::PCW:0]          drem_q;
  logic [5:0]                     dit_q;
  logic                           ovalid_q;

  logic                           start, load_out;
  logic [clf_pkg::ROOTW+2:0]      srem, strial;
  logic                           sge;
  logic [clf_pkg::PCW+1:0]        dr;
  logic                           dge;
  logic [clf_pkg::LOSSW:0]        lsum;
  logic [64:0]                    rnd;
  logic [clf_pkg::PCW-1:0]        pc_next;
  logic                           pc_sat;

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      clf_pkg::B_IDLE: begin
        if (!q_empty_i) begin
          if (q_data_i.similar || legacy_i) st_d = clf_pkg::B_ACC;
          else                              st_d = clf_pkg::B_SQRT;
        end
      end
      clf_pkg::B_SQRT: if (it_q == 5'(clf_pkg::ROOTW - 1)) st_d = clf_pkg::B_MUL;
      clf_pkg::B_MUL:  st_d = clf_pkg::B_RND;
      clf_pkg::B_RND:  st_d = clf_pkg::B_ACC;
      clf_pkg::B_ACC:  st_d = ent_q.last_pair ? clf_pkg::B_DIV : clf_pkg::B_IDLE;
      clf_pkg::B_DIV:  if (dit_q == 6'd63) st_d = clf_pkg::B_OUT;
      clf_pkg::B_OUT:  if (!ovalid_q || pop_i) st_d = clf_pkg::B_IDLE;
      default:         st_d = clf_pkg::B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    start    = (st_q == clf_pkg::B_IDLE) && !q_empty_i;
    load_out = (st_q == clf_pkg::B_OUT) && (!ovalid_q || pop_i);
    q_pop_o  = start;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= clf_pkg::B_IDLE;
    else         st_q <= st_d;
  end

  // one root bit per cycle: bring down two radicand bits
  assign srem   = {rem_q[clf_pkg::ROOTW:0], x_q[XW-1 -: 2]};
  assign strial = {1'b0, root_q, 2'b01};
  assign sge    = srem >= strial;

  // one quotient bit per cycle
  assign dr  = {drem_q, dvd_q[63]};
  assign dge = dr >= {1'b0, dsr_q};

  assign rnd  = {1'b0, prod_q} + 65'd32768;
  assign lsum = {1'b0, loss_q} + (clf_pkg::LOSSW + 1)'(term_q);
  assign pc_sat  = pc_q >= PC_MAX;
  assign pc_next = pc_sat ? PC_MAX : clf_pkg::PCW'(pc_q + 1'b1);

  always_ff @(posedge clk_i) begin
    if (start) begin
      ent_q  <= q_data_i;
      x_q    <= XW'({q_data_i.d2, 16'd0});
      root_q <= '0;
      rem_q  <= '0;
      it_q   <= '0;
      if (q_data_i.similar) begin
        term_q <= clf_pkg::TERMW'(q_data_i.d2);
      end else begin
        term_q <= ({11'd0, margin_i} > q_data_i.d2)
                  ? clf_pkg::TERMW'({11'd0, margin_i} - q_data_i.d2) : '0;
      end
    end
    if (st_q == clf_pkg::B_SQRT) begin
      x_q    <= {x_q[XW-3:0], 2'b00};
      rem_q  <= sge ? srem - strial : srem;
      root_q <= {root_q[clf_pkg::ROOTW-2:0], sge};
      it_q   <= 5'(it_q + 1'b1);
    end
    if (st_q == clf_pkg::B_MUL) begin
      prod_q <= (margin_i > clf_pkg::MARGINW'(root_q))
                ? 64'(margin_i - clf_pkg::MARGINW'(root_q))
                  * 64'(margin_i - clf_pkg::MARGINW'(root_q))
                : 64'd0;
    end
    if (st_q == clf_pkg::B_RND) begin
      term_q <= rnd[63:16];
    end
    if (st_q == clf_pkg::B_ACC) begin
      dvd_q  <= lsum[clf_pkg::LOSSW] ? '1 : lsum[clf_pkg::LOSSW-1:0];
      dsr_q  <= {pc_next, 1'b0};
      drem_q <= '0;
      dit_q  <= '0;
    end
    if (st_q == clf_pkg::B_DIV) begin
      dvd_q  <= {dvd_q[62:0], 1'b0};
      quo_q  <= {quo_q[62:0], dge};
      drem_q <= dge ? (clf_pkg::PCW + 1)'(dr - {1'b0, dsr_q})
                    : dr[clf_pkg::PCW:0];
      dit_q  <= 6'(dit_q + 1'b1);
    end
    if (load_out) begin
      loss_value_o     <= (|quo_q[63:clf_pkg::OUTW]) ? '1 : quo_q[clf_pkg::OUTW-1:0];
      loss_saturated_o <= flag_q | (|quo_q[63:clf_pkg::OUTW]);
      pair_total_o     <= pc_q;
    end
  end

  // batch accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loss_q   <= '0;
      pc_q     <= '0;
      flag_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (st_q == clf_pkg::B_ACC) begin
        loss_q <= lsum[clf_pkg::LOSSW] ? '1 : lsum[clf_pkg::LOSSW-1:0];
        pc_q   <= pc_next;
        flag_q <= flag_q | ent_q.ovf | lsum[clf_pkg::LOSSW] | pc_sat;
      end
      if (load_out) begin
        loss_q <= '0;
        pc_q   <= '0;
        flag_q <= 1'b0;
      end
      if (load_out)               ovalid_q <= 1'b1;
      else if (pop_i && ovalid_q) ovalid_q <= 1'b0;
    end
  end

  assign empty_o = ~ovalid_q;

endmodule

// File: rtl/contrastive_loss_forward_top.sv
// contrastive loss forward pass, squared euclidean distance with margin
// The input side is a queue: drive push_i with an element pair (elem_a_i,
// elem_b_i) and its flags; it is taken on a clock edge with push_i high and
// full_o low. last_channel_i closes a vector pair (similar_pair_i is sampled
// there); last_pair_i together with last_channel_i closes the batch.
// The result side is a queue too: while empty_o is low the batch loss,
// saturation flag and pair count are on the outputs, taken with pop_i.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 margin Q16.16, 1 legacy mode) in the same cycle; write only when idle.
// Throughput: the front takes one element per cycle while full_o is low.
// Each closed vector pair goes straight to accumulation in the back end
// (similar or legacy) or first through the square root (one root bit per
// cycle over 30 bits, then multiply and round); closing a batch adds the
// bit-serial divide and output load. A 4-entry pair queue sits between
// the two, so full_o rises only when the back end falls behind. The result
// waits in an output register while pop_i is low; the back end then holds
// and the queue fills. Reset clears all sums and counters and restores
// margin 1.0 and legacy mode off.
`include "contrastive_loss_forward_top_defines.svh"
module contrastive_loss_forward_top #(
  parameter int unsigned PAIRS_MAX = clf_pkg::PAIRS_MAX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic signed [15:0]          elem_a_i,
  input  logic signed [15:0]          elem_b_i,
  input  logic                        similar_pair_i,
  input  logic                        last_channel_i,
  input  logic                        last_pair_i,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [clf_pkg::OUTW-1:0]    loss_value_o,
  output logic                        loss_saturated_o,
  output logic [clf_pkg::PCW-1:0]     pair_total_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [clf_pkg::MARGINW-1:0] cfg_wdata_i
);

  logic [clf_pkg::MARGINW-1:0] margin_q;
  logic                        legacy_q;
  logic                        q_push, q_pop, q_empty;
  logic [clf_pkg::QCNTW-1:0]   q_cnt;
  clf_pkg::pair_t              q_in, q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= clf_pkg::MARGINW'(65536);
      legacy_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (clf_pkg::reg_idx_e'(cfg_idx_i))
        clf_pkg::REG_MARGIN: margin_q <= cfg_wdata_i;
        clf_pkg::REG_LEGACY: legacy_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  clf_front u_front (
    .clk_i, .rst_ni, .push_i, .full_o,
    .elem_a_i, .elem_b_i, .similar_pair_i, .last_channel_i, .last_pair_i,
    .q_cnt_i  (q_cnt),
    .q_push_o (q_push),
    .q_data_o (q_in)
  );

  clf_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (q_push),
    .data_i  (q_in),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty),
    .cnt_o   (q_cnt)
  );

  clf_back #(.PAIRS_MAX(PAIRS_MAX)) u_back (
    .clk_i, .rst_ni,
    .margin_i  (margin_q),
    .legacy_i  (legacy_q),
    .q_empty_i (q_empty),
    .q_data_i  (q_out),
    .q_pop_o   (q_pop),
    .empty_o, .pop_i, .loss_value_o, .loss_saturated_o, .pair_total_o
  );

  `CLF_ASSERT_IMP(a_q_no_overflow, q_push, 32'(q_cnt) < clf_pkg::QDEPTH)
  `CLF_ASSERT_IMP(a_q_no_underflow, q_pop, !q_empty)
  `CLF_ASSERT_IMP(a_pairs_counted, !empty_o, pair_total_o != '0)

endmodule
